// ===== src/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by mexp_mulmod and modular_exponentiation_top.
package mexp_pkg;

  localparam int OpBits  = 34;
  localparam int CntW    = $clog2(OpBits);
  localparam int CfgIdxW = 1;

  typedef logic [OpBits-1:0] op_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_WAIT,
    ST_DONE
  } mexp_state_e;

endpackage

// ===== src/modular_exponentiation_top.sv =====
// Top level: right-to-left square and multiply modular exponentiation.
// Depends on mexp_pkg and mexp_mulmod (two instances: square and multiply).
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, base_value_i      | request in
//  out     | out_valid_o, out_ready_i, power_result_o  | request out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | write only
//
// One request at a time. The base is first reduced mod N, then each exponent bit
// up to the highest set one costs one round in which the bit-serial square and
// multiply units run side by side; the next request can be taken in the cycle
// after the result is loaded. A finished result sits in the output register, so
// the next request is accepted while it waits. Reset gives N = 1 and exponent 0.
module modular_exponentiation_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  mexp_pkg::op_t            base_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output mexp_pkg::op_t            power_result_o,
  input  logic                     cfg_we_i,
  input  logic [mexp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  mexp_pkg::op_t            cfg_data_i
);
  import mexp_pkg::*;

  mexp_state_e state_q, state_d;

  op_t  mod_q, exp_q;
  op_t  base_q, acc_q, e_q, out_q;
  logic out_valid_q;

  logic sq_start, ac_start;
  op_t  sq_a, sq_mult;
  logic sq_done, ac_done;
  op_t  sq_res, ac_res;

  logic in_acc, out_load;

  assign in_acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    sq_start   = 1'b0;
    ac_start   = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sq_start = 1'b1;  // reduce base: 1 * base mod N
          state_d  = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (sq_done) begin
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (e_q == '0) begin
          state_d = ST_DONE;
        end else begin
          sq_start = 1'b1;
          ac_start = 1'b1;
          state_d  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (sq_done) begin
          state_d = ST_STEP;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= OpBits'(1);
      exp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODULUS:  mod_q <= cfg_data_i;
          REG_EXPONENT: exp_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      base_q <= base_value_i;
    end
    if (state_q == ST_REDUCE && sq_done) begin
      base_q <= sq_res;
      acc_q  <= OpBits'(1);
      e_q    <= exp_q;
    end
    if (state_q == ST_WAIT && sq_done) begin
      base_q <= sq_res;
      if (e_q[0]) begin
        acc_q <= ac_res;
      end
      e_q <= e_q >> 1;
    end
    if (out_load) begin
      out_q <= acc_q;
    end
  end

  // the squaring unit doubles as the base reducer (operand a = 1)
  assign sq_a    = (state_q inside {ST_IDLE, ST_REDUCE}) ? OpBits'(1) : base_q;
  assign sq_mult = (state_q == ST_IDLE) ? base_value_i : base_q;

  mexp_mulmod u_sq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sq_start),
    .a_i      (sq_a),
    .mult_i   (sq_mult),
    .mod_i    (mod_q),
    .done_o   (sq_done),
    .result_o (sq_res)
  );

  mexp_mulmod u_ac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ac_start),
    .a_i      (acc_q),
    .mult_i   (base_q),
    .mod_i    (mod_q),
    .done_o   (ac_done),
    .result_o (ac_res)
  );

  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_q;

  a_units_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WAIT |-> sq_done == ac_done)
    else $error("square and multiply units out of step");

  a_accept_reduces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_REDUCE)
    else $error("accepted request did not start reduction");

  a_base_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_STEP && mod_q != '0 |-> base_q < mod_q)
    else $error("base not reduced below modulus");

  a_no_ac_outside_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ac_done |-> state_q == ST_WAIT)
    else $error("multiply result arrived outside a round");

endmodule

// ===== src/mexp_mulmod.sv =====
// Bit-serial interleaved modular multiplier: (a * mult) mod m, m == 0 wraps.
// Depends on mexp_pkg. Each multiplier bit takes a double step, then an add step.
module mexp_mulmod (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mexp_pkg::op_t  a_i,
  input  mexp_pkg::op_t  mult_i,
  input  mexp_pkg::op_t  mod_i,
  output logic           done_o,
  output mexp_pkg::op_t  result_o
);
  import mexp_pkg::*;

  op_t             r_q, r_d;
  op_t             mult_q;
  logic [CntW-1:0] cnt_q;
  logic            phase_q;
  logic            busy_q;
  logic            done_q;

  op_t             opnd;
  logic [OpBits:0] sum;
  logic            sub;

  // phase 0 doubles r, phase 1 adds a when the current multiplier bit is set;
  // both operands stay <= m, so one conditional subtract reduces the sum
  always_comb begin
    opnd = phase_q ? (mult_q[OpBits-1] ? a_i : '0) : r_q;
    sum  = {1'b0, r_q} + {1'b0, opnd};
    sub  = (mod_i != '0) && (sum >= {1'b0, mod_i});
    r_d  = sub ? OpBits'(sum - {1'b0, mod_i}) : sum[OpBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= '0;
      end else if (busy_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(OpBits - 1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q    <= '0;
      mult_q <= mult_i;
    end else if (busy_q) begin
      r_q <= r_d;
      if (phase_q) begin
        mult_q <= mult_q << 1;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = r_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("mulmod done without a running product");

  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && mod_i != '0 && r_q < mod_i && a_i <= mod_i |=> r_q < mod_i)
    else $error("mulmod partial result left unreduced");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < CntW'(OpBits))
    else $error("mulmod bit counter overran");

endmodule
